// ----- sv/assert_macros.svh -----
// Assertion macros shared by the interpreter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PEI_ASSERT_IMPLY(name, clk, rst, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PEI_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ----- sv/pei_pkg.sv -----
// Types, codes and constants of the printer escape interpreter.
// No dependencies; used by printer_escape_interpreter_core.
package pei_pkg;

  localparam int unsigned DOT_W   = 14;
  localparam int unsigned ROWS_W  = 9;
  localparam int unsigned PIN_W   = 8;
  localparam int unsigned INK_W   = 3;
  localparam int unsigned CODE_W  = 7;
  localparam int unsigned COUNT_W = 16;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_PARAM = 2'd2,
    MODE_GFX   = 2'd3
  } parse_mode_t;

  typedef enum logic [2:0] {
    EV_LINE_FEED     = 3'd0,
    EV_FORM_FEED     = 3'd1,
    EV_UNKNOWN_CMD   = 3'd2,
    EV_COLOR_CHANGE  = 3'd3,
    EV_RESET_SEEN    = 3'd4,
    EV_HEAD_BURST    = 3'd5,
    EV_COLUMN_STRIKE = 3'd6,
    EV_TEXT_CHAR     = 3'd7
  } event_kind_t;

  // Control characters in text mode.
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_FF    = 7'h0C;
  localparam logic [6:0] CH_ESC   = 7'h1B;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_DEL   = 7'h7F;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_SIX   = 7'h36;

  // Command letters following ESC.
  localparam logic [6:0] CMD_GFX_NATIVE = 7'h47; // G
  localparam logic [6:0] CMD_GFX_120    = 7'h4C; // L
  localparam logic [6:0] CMD_LF_DIGITS  = 7'h54; // T
  localparam logic [6:0] CMD_LF_BINARY  = 7'h41; // A
  localparam logic [6:0] CMD_LF_18      = 7'h42; // B
  localparam logic [6:0] CMD_INK        = 7'h4B; // K
  localparam logic [6:0] CMD_RESET      = 7'h63; // c
  localparam logic [6:0] CMD_PITCH_17   = 7'h6E; // n
  localparam logic [6:0] CMD_PITCH_16   = 7'h4E; // N
  localparam logic [6:0] CMD_PITCH_13   = 7'h45; // E
  localparam logic [6:0] CMD_PITCH_12   = 7'h65; // e
  localparam logic [6:0] CMD_PITCH_10   = 7'h71; // q
  localparam logic [6:0] CMD_PITCH_9    = 7'h51; // Q
  localparam logic [6:0] CMD_NOP_GT     = 7'h3E; // >
  localparam logic [6:0] CMD_NOP_LT     = 7'h3C; // <
  localparam logic [6:0] CMD_NOP_P      = 7'h50; // P

  // Parameter counts of the commands that take parameters.
  localparam logic [2:0] NEED_GFX_NATIVE = 3'd4;
  localparam logic [2:0] NEED_GFX_120    = 3'd2;
  localparam logic [2:0] NEED_LF_DIGITS  = 3'd2;
  localparam logic [2:0] NEED_ONE        = 3'd1;

  // Reset values and fixed settings.
  localparam logic [DOT_W-1:0]  MARGIN_RESET = 14'd1280;
  localparam logic [ROWS_W-1:0] LF_ROWS_RESET = 9'd24;
  localparam logic [ROWS_W-1:0] LF_ROWS_B     = 9'd18;
  localparam logic [4:0] PITCH_RESET = 5'd16;
  localparam logic [4:0] PITCH_17    = 5'd17;
  localparam logic [4:0] PITCH_16    = 5'd16;
  localparam logic [4:0] PITCH_13    = 5'd13;
  localparam logic [4:0] PITCH_12    = 5'd12;
  localparam logic [4:0] PITCH_10    = 5'd10;
  localparam logic [4:0] PITCH_9     = 5'd9;
  localparam logic [INK_W-1:0] INK_BLACK = 3'd0;

  // One result item as it leaves the block.
  typedef struct packed {
    event_kind_t         kind;
    logic [ROWS_W-1:0]   rows;
    logic [DOT_W-1:0]    from_dot;
    logic [DOT_W-1:0]    to_dot;
    logic [PIN_W-1:0]    pins;
    logic [INK_W-1:0]    ink;
    logic [CODE_W-1:0]   code;
    logic                last;
  } result_t;

  // Value of an ASCII decimal digit; anything else counts as zero.
  function automatic logic [3:0] digit_value(input logic [7:0] p);
    logic [6:0] c;
    logic [6:0] d;
    c = p[6:0];
    d = c - CH_ZERO;
    return (c >= CH_ZERO && c <= CH_NINE) ? d[3:0] : 4'd0;
  endfunction

  // Ink selected by an ASCII digit; anything outside '0'..'6' is black.
  function automatic logic [INK_W-1:0] ink_from_digit(input logic [7:0] p);
    logic [6:0] c;
    logic [INK_W-1:0] ink;
    c = p[6:0];
    ink = INK_BLACK;
    if (c >= CH_ZERO && c <= CH_SIX) begin
      case (c[2:0])
        3'd0: ink = 3'd0;
        3'd1: ink = 3'd1;
        3'd2: ink = 3'd2;
        3'd3: ink = 3'd4;
        3'd4: ink = 3'd3;
        3'd5: ink = 3'd5;
        3'd6: ink = 3'd6;
        default: ink = INK_BLACK;
      endcase
    end
    return ink;
  endfunction

  // Result record with the ink filled in later.
  function automatic result_t make_result(input event_kind_t kind,
                                          input logic [ROWS_W-1:0] rows,
                                          input logic [DOT_W-1:0] from_dot,
                                          input logic [DOT_W-1:0] to_dot,
                                          input logic [PIN_W-1:0] pins,
                                          input logic [CODE_W-1:0] code,
                                          input logic last);
    result_t r;
    r.kind     = kind;
    r.rows     = rows;
    r.from_dot = from_dot;
    r.to_dot   = to_dot;
    r.pins     = pins;
    r.ink      = INK_BLACK;
    r.code     = code;
    r.last     = last;
    return r;
  endfunction

endpackage

// ----- sv/printer_escape_interpreter_core.sv -----
// Printer escape interpreter: byte stream in, ordered printer events out.
// Depends on pei_pkg and assert_macros.svh.
//
//   Channel   Handshake                  Payload
//   cfg       cfg_valid / cfg_ready      cfg_data (right margin in dots)
//   data      data_valid / data_stall    data_byte
//   event     event_valid / event_stall  event_kind, feed_rows, from_dot, to_dot,
//                                        pin_bits, ink_color, code_byte, last
//
// Each byte is decoded in the cycle it is taken; its results appear on the
// event ports from the next cycle. A wrapped text character and the end of a
// bit-image burst give two results each; the second waits in the spare result
// slot. Reset is synchronous and clears the parser, head and slot-valid state,
// but not the stored parameter bytes; the margin register returns to 1280 dots.
// The data side stalls while the spare result slot is full or the head slot
// is held by event_stall.

`include "assert_macros.svh"

module printer_escape_interpreter_core #(
  parameter int unsigned HEAD_DOT_LIMIT = 16383
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pei_pkg::DOT_W-1:0]          cfg_data,
  input  logic                               data_valid,
  output logic                               data_stall,
  input  logic [7:0]                         data_byte,
  output logic                               event_valid,
  input  logic                               event_stall,
  output logic [2:0]                         event_kind,
  output logic [pei_pkg::ROWS_W-1:0]         feed_rows,
  output logic [pei_pkg::DOT_W-1:0]          from_dot,
  output logic [pei_pkg::DOT_W-1:0]          to_dot,
  output logic [pei_pkg::PIN_W-1:0]          pin_bits,
  output logic [pei_pkg::INK_W-1:0]          ink_color,
  output logic [pei_pkg::CODE_W-1:0]         code_byte,
  output logic                               last
);

  localparam int unsigned HW = $clog2(HEAD_DOT_LIMIT + 1);
  localparam int unsigned SW = HW + 18;
  localparam logic [HW-1:0] LIMIT = HW'(HEAD_DOT_LIMIT);

  // Saturate a widened dot position at the head limit.
  function automatic logic [HW-1:0] sat_dot(input logic [SW-1:0] v);
    return (v > SW'(HEAD_DOT_LIMIT)) ? LIMIT : v[HW-1:0];
  endfunction

  // Parser and head state.
  logic [pei_pkg::DOT_W-1:0]   right_margin_dots;
  pei_pkg::parse_mode_t        parse_mode, parse_mode_next;
  logic [6:0]                  command_letter, command_letter_next;
  logic [2:0]                  params_needed, params_needed_next;
  logic [2:0]                  params_got, params_got_next;
  logic [7:0]                  param_store [4];
  logic [pei_pkg::COUNT_W-1:0] columns_left, columns_left_next;
  logic                        msb_is_top, msb_is_top_next;
  logic [14:0]                 col_third, col_third_next;
  logic [1:0]                  col_phase, col_phase_next;
  logic [HW-1:0]               burst_start_dot, burst_start_dot_next;
  logic [HW-1:0]               burst_first_dot, burst_first_dot_next;
  logic                        burst_first_valid, burst_first_valid_next;
  logic [HW-1:0]               head_column, head_column_next;
  logic [pei_pkg::ROWS_W-1:0]  line_feed_rows, line_feed_rows_next;
  logic [4:0]                  pitch_dots, pitch_dots_next;
  logic [pei_pkg::INK_W-1:0]   current_ink, current_ink_next;

  // Decode results and result slots.
  pei_pkg::result_t res_a, res_b;
  logic [1:0]       res_count;
  pei_pkg::result_t slot0, slot1;
  logic             slot0_valid, slot1_valid;
  logic             accept, pop;
  logic             pstore_we;
  logic [1:0]       pstore_idx;
  logic [7:0]       pv [4];

  // Arithmetic helpers.
  logic [6:0]    b;
  logic [SW-1:0] cell_end, text_start, gfx_d0, gfx_d1;
  logic          wrap;
  logic [HW-1:0] col_from, col_to;
  logic [7:0]    col_pins;
  logic [pei_pkg::COUNT_W-1:0] cols_dec, burst_count;
  logic [13:0]   g_count;
  logic [6:0]    t_count;

  assign b = data_byte[6:0];

  // Handshakes: a byte is taken only while the spare slot is empty and the head slot is empty or being taken.
  assign cfg_ready  = 1'b1;
  assign data_stall = slot1_valid || (slot0_valid && event_stall);
  assign accept     = data_valid && !data_stall;
  assign pop        = slot0_valid && !event_stall;

  // Parameter bytes as seen by the executing command, including this byte.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pv[i] = (pstore_we && pstore_idx == 2'(i)) ? data_byte : param_store[i];
    end
  end

  // Count values from parameter digits and binary bytes.
  always_comb begin
    g_count = 14'(pei_pkg::digit_value(pv[0])) * 14'd1000
            + 14'(pei_pkg::digit_value(pv[1])) * 14'd100
            + 14'(pei_pkg::digit_value(pv[2])) * 14'd10
            + 14'(pei_pkg::digit_value(pv[3]));
    t_count = 7'(pei_pkg::digit_value(pv[0])) * 7'd10
            + 7'(pei_pkg::digit_value(pv[1]));
    burst_count = {pv[1], pv[0]};
  end

  // Text cell placement and wrap test.
  always_comb begin
    wrap       = (SW'(head_column) + SW'(pitch_dots)) > SW'(right_margin_dots);
    text_start = wrap ? '0 : SW'(head_column);
    cell_end   = text_start + SW'(pitch_dots);
  end

  // Column span: native columns follow the head, 120 dpi columns map four
  // dots to three columns from the burst start (index = 3 * third + phase).
  always_comb begin
    if (msb_is_top) begin
      gfx_d0 = SW'(burst_start_dot) + SW'({col_third, 2'b00}) + SW'(col_phase);
      gfx_d1 = gfx_d0 + SW'(1) + SW'(col_phase == 2'd2);
      for (int i = 0; i < pei_pkg::PIN_W; i++) begin
        col_pins[i] = data_byte[pei_pkg::PIN_W - 1 - i];
      end
    end else begin
      gfx_d0   = SW'(head_column);
      gfx_d1   = gfx_d0 + SW'(1);
      col_pins = data_byte;
    end
    col_from = sat_dot(gfx_d0);
    col_to   = sat_dot(gfx_d1 - SW'(1));
    cols_dec = columns_left - 1'b1;
  end

  // Next state and results for the byte on the data port.
  always_comb begin
    parse_mode_next        = parse_mode;
    command_letter_next    = command_letter;
    params_needed_next     = params_needed;
    params_got_next        = params_got;
    columns_left_next      = columns_left;
    msb_is_top_next        = msb_is_top;
    col_third_next         = col_third;
    col_phase_next         = col_phase;
    burst_start_dot_next   = burst_start_dot;
    burst_first_dot_next   = burst_first_dot;
    burst_first_valid_next = burst_first_valid;
    head_column_next       = head_column;
    line_feed_rows_next    = line_feed_rows;
    pitch_dots_next        = pitch_dots;
    current_ink_next       = current_ink;
    pstore_we              = 1'b0;
    pstore_idx             = params_got[1:0];
    res_a     = pei_pkg::make_result(pei_pkg::EV_LINE_FEED, '0, '0, '0, '0, '0, 1'b1);
    res_b     = res_a;
    res_count = 2'd0;

    case (parse_mode)
      pei_pkg::MODE_IDLE: begin
        if (b == pei_pkg::CH_CR) begin
          head_column_next = '0;
        end else if (b == pei_pkg::CH_LF) begin
          res_a = pei_pkg::make_result(pei_pkg::EV_LINE_FEED, line_feed_rows,
                                       '0, '0, '0, '0, 1'b1);
          res_count = 2'd1;
        end else if (b == pei_pkg::CH_FF) begin
          head_column_next = '0;
          res_a = pei_pkg::make_result(pei_pkg::EV_FORM_FEED, '0, '0, '0, '0, '0, 1'b1);
          res_count = 2'd1;
        end else if (b == pei_pkg::CH_ESC) begin
          parse_mode_next = pei_pkg::MODE_ESC;
        end else if (b >= pei_pkg::CH_SPACE && b != pei_pkg::CH_DEL &&
                     pitch_dots != '0) begin
          // A cell crossing the margin is preceded by a wrapping line feed.
          head_column_next = sat_dot(cell_end);
          if (wrap) begin
            res_a = pei_pkg::make_result(pei_pkg::EV_LINE_FEED, line_feed_rows,
                                         '0, '0, '0, '0, 1'b0);
            res_b = pei_pkg::make_result(pei_pkg::EV_TEXT_CHAR, '0,
                                         14'(text_start),
                                         14'(sat_dot(cell_end - SW'(1))),
                                         '0, b, 1'b1);
            res_count = 2'd2;
          end else begin
            res_a = pei_pkg::make_result(pei_pkg::EV_TEXT_CHAR, '0,
                                         14'(text_start),
                                         14'(sat_dot(cell_end - SW'(1))),
                                         '0, b, 1'b1);
            res_count = 2'd1;
          end
        end
      end

      pei_pkg::MODE_ESC: begin
        command_letter_next = b;
        params_got_next     = '0;
        parse_mode_next     = pei_pkg::MODE_IDLE;
        case (b)
          pei_pkg::CMD_GFX_NATIVE: begin
            params_needed_next = pei_pkg::NEED_GFX_NATIVE;
            parse_mode_next    = pei_pkg::MODE_PARAM;
          end
          pei_pkg::CMD_GFX_120, pei_pkg::CMD_LF_DIGITS: begin
            params_needed_next = pei_pkg::NEED_GFX_120;
            parse_mode_next    = pei_pkg::MODE_PARAM;
          end
          pei_pkg::CMD_INK, pei_pkg::CMD_LF_BINARY: begin
            params_needed_next = pei_pkg::NEED_ONE;
            parse_mode_next    = pei_pkg::MODE_PARAM;
          end
          pei_pkg::CMD_LF_18:    line_feed_rows_next = pei_pkg::LF_ROWS_B;
          pei_pkg::CMD_PITCH_17: pitch_dots_next = pei_pkg::PITCH_17;
          pei_pkg::CMD_PITCH_16: pitch_dots_next = pei_pkg::PITCH_16;
          pei_pkg::CMD_PITCH_13: pitch_dots_next = pei_pkg::PITCH_13;
          pei_pkg::CMD_PITCH_12: pitch_dots_next = pei_pkg::PITCH_12;
          pei_pkg::CMD_PITCH_10: pitch_dots_next = pei_pkg::PITCH_10;
          pei_pkg::CMD_PITCH_9:  pitch_dots_next = pei_pkg::PITCH_9;
          pei_pkg::CMD_NOP_GT, pei_pkg::CMD_NOP_LT, pei_pkg::CMD_NOP_P: begin
          end
          pei_pkg::CMD_RESET: begin
            // Software reset: everything but the margin register and the stored parameter bytes.
            command_letter_next    = '0;
            params_needed_next     = '0;
            columns_left_next      = '0;
            msb_is_top_next        = 1'b0;
            col_third_next         = '0;
            col_phase_next         = '0;
            burst_start_dot_next   = '0;
            burst_first_dot_next   = '0;
            burst_first_valid_next = 1'b0;
            head_column_next       = '0;
            line_feed_rows_next    = pei_pkg::LF_ROWS_RESET;
            pitch_dots_next        = pei_pkg::PITCH_RESET;
            current_ink_next       = pei_pkg::INK_BLACK;
            res_a = pei_pkg::make_result(pei_pkg::EV_RESET_SEEN, '0, '0, '0, '0, '0, 1'b1);
            res_count = 2'd1;
          end
          default: begin
            res_a = pei_pkg::make_result(pei_pkg::EV_UNKNOWN_CMD, '0, '0, '0, '0, b, 1'b1);
            res_count = 2'd1;
          end
        endcase
      end

      pei_pkg::MODE_PARAM: begin
        pstore_we       = 1'b1;
        params_got_next = params_got + 1'b1;
        if (params_got_next >= params_needed) begin
          parse_mode_next = pei_pkg::MODE_IDLE;
          case (command_letter)
            pei_pkg::CMD_GFX_NATIVE: begin
              msb_is_top_next        = 1'b0;
              columns_left_next      = 16'(g_count);
              burst_first_valid_next = 1'b0;
              if (g_count != '0) parse_mode_next = pei_pkg::MODE_GFX;
            end
            pei_pkg::CMD_GFX_120: begin
              msb_is_top_next        = 1'b1;
              col_third_next         = '0;
              col_phase_next         = '0;
              burst_start_dot_next   = head_column;
              columns_left_next      = burst_count;
              burst_first_valid_next = 1'b0;
              if (burst_count != '0) parse_mode_next = pei_pkg::MODE_GFX;
            end
            pei_pkg::CMD_LF_DIGITS: begin
              if (t_count != '0) line_feed_rows_next = 9'(t_count);
            end
            pei_pkg::CMD_LF_BINARY: begin
              if (pv[0] != '0) line_feed_rows_next = {pv[0], 1'b0};
            end
            pei_pkg::CMD_INK: begin
              current_ink_next = pei_pkg::ink_from_digit(pv[0]);
              res_a = pei_pkg::make_result(pei_pkg::EV_COLOR_CHANGE, '0, '0, '0, '0, '0,
                                           1'b1);
              res_count = 2'd1;
            end
            default: begin
            end
          endcase
        end
      end

      pei_pkg::MODE_GFX: begin
        // One column per byte; the last column also closes the burst.
        if (!burst_first_valid) burst_first_dot_next = col_from;
        burst_first_valid_next = 1'b1;
        head_column_next       = sat_dot(gfx_d1);
        columns_left_next      = cols_dec;
        if (col_phase == 2'd2) begin
          col_phase_next = '0;
          col_third_next = col_third + 1'b1;
        end else begin
          col_phase_next = col_phase + 1'b1;
        end
        if (cols_dec == '0) begin
          parse_mode_next = pei_pkg::MODE_IDLE;
          res_a = pei_pkg::make_result(pei_pkg::EV_COLUMN_STRIKE, '0, 14'(col_from),
                                       14'(col_to), col_pins, '0, 1'b0);
          res_b = pei_pkg::make_result(pei_pkg::EV_HEAD_BURST, '0,
                                       14'(burst_first_dot_next), 14'(col_to),
                                       '0, '0, 1'b1);
          res_count = 2'd2;
        end else begin
          res_a = pei_pkg::make_result(pei_pkg::EV_COLUMN_STRIKE, '0, 14'(col_from),
                                       14'(col_to), col_pins, '0, 1'b1);
          res_count = 2'd1;
        end
      end

      default: begin
        parse_mode_next = pei_pkg::MODE_IDLE;
      end
    endcase

    // Every event reports the ink as it stands after this byte.
    res_a.ink = current_ink_next;
    res_b.ink = current_ink_next;
  end

  // Margin register.
  always_ff @(posedge clk) begin
    if (rst) begin
      right_margin_dots <= pei_pkg::MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      right_margin_dots <= cfg_data;
    end
  end

  // Parameter bytes.
  always_ff @(posedge clk) begin
    if (accept && pstore_we) begin
      param_store[pstore_idx] <= data_byte;
    end
  end

  // Interpreter state, updated on each transfer on the data side.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode        <= pei_pkg::MODE_IDLE;
      command_letter    <= '0;
      params_needed     <= '0;
      params_got        <= '0;
      columns_left      <= '0;
      msb_is_top        <= 1'b0;
      col_third         <= '0;
      col_phase         <= '0;
      burst_start_dot   <= '0;
      burst_first_dot   <= '0;
      burst_first_valid <= 1'b0;
      head_column       <= '0;
      line_feed_rows    <= pei_pkg::LF_ROWS_RESET;
      pitch_dots        <= pei_pkg::PITCH_RESET;
      current_ink       <= pei_pkg::INK_BLACK;
    end else if (accept) begin
      parse_mode        <= parse_mode_next;
      command_letter    <= command_letter_next;
      params_needed     <= params_needed_next;
      params_got        <= params_got_next;
      columns_left      <= columns_left_next;
      msb_is_top        <= msb_is_top_next;
      col_third         <= col_third_next;
      col_phase         <= col_phase_next;
      burst_start_dot   <= burst_start_dot_next;
      burst_first_dot   <= burst_first_dot_next;
      burst_first_valid <= burst_first_valid_next;
      head_column       <= head_column_next;
      line_feed_rows    <= line_feed_rows_next;
      pitch_dots        <= pitch_dots_next;
      current_ink       <= current_ink_next;
    end
  end

  // Result slots: the head drives the event port, the spare holds the
  // second result of a byte until the head has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_valid <= 1'b0;
      slot1_valid <= 1'b0;
    end else if (accept) begin
      slot0_valid <= (res_count != 2'd0);
      slot1_valid <= (res_count == 2'd2);
    end else if (pop) begin
      slot0_valid <= slot1_valid;
      slot1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= res_a;
      slot1 <= res_b;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  // Event port.
  assign event_valid = slot0_valid;
  assign event_kind  = slot0.kind;
  assign feed_rows   = slot0.rows;
  assign from_dot    = slot0.from_dot;
  assign to_dot      = slot0.to_dot;
  assign pin_bits    = slot0.pins;
  assign ink_color   = slot0.ink;
  assign code_byte   = slot0.code;
  assign last        = slot0.last;

  // Checks on slot ordering and parser bookkeeping.
  `PEI_ASSERT_IMPLY(a_spare_needs_head, clk, rst, slot1_valid, slot0_valid, "spare slot full with head empty")
  `PEI_ASSERT_IMPLY(a_spare_after_first, clk, rst, slot1_valid, !slot0.last, "head result before spare marked last")
  `PEI_ASSERT_IMPLY(a_burst_has_columns, clk, rst, parse_mode == pei_pkg::MODE_GFX, columns_left != '0, "burst mode with no columns left")
  `PEI_ASSERT_IMPLY(a_params_pending, clk, rst, parse_mode == pei_pkg::MODE_PARAM, params_got < params_needed, "parameter mode with all parameters taken")
  `PEI_ASSERT_NEXT(a_pair_stored, clk, rst, accept && res_count == 2'd2, slot0_valid && slot1_valid, "pair of results not held in both slots")

endmodule
